// File: hdl/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication checked on the rising clock edge, switched off while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: hdl/fncp_pkg.sv
// Shared types and constants of the flat name component parser.
`default_nettype none
package fncp_pkg;

  localparam int LEN_W           = 21;
  localparam int NUM_W           = 16;
  localparam int DB_W            = 2;
  localparam int MAX_DELIM_BYTES = 3;
  localparam int DEF_QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_COMP = 2'd0,
    KIND_DONE = 2'd1,
    KIND_BAD  = 2'd2
  } kind_t;

  // Results that one input byte causes: an optional component report and an
  // optional end-of-name report.
  typedef struct packed {
    logic             comp_valid;
    logic [LEN_W-1:0] comp_len;
    logic [DB_W-1:0]  comp_db;
    logic [NUM_W-1:0] comp_idx;
    logic             end_valid;
    logic             end_bad;
    logic [NUM_W-1:0] end_count;
  } entry_t;

endpackage
`default_nettype wire

// File: hdl/fncp_front.sv
// Front part: parses each byte and classifies the results it causes.
`default_nettype none
module fncp_front
  import fncp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire logic       final_byte,
  output logic            push,
  output entry_t          entry
);

  logic             in_data, in_data_next;
  logic [LEN_W-1:0] length_accum, length_accum_next;
  logic [DB_W-1:0]  delim_count, delim_count_next;
  logic [LEN_W-1:0] bytes_left, bytes_left_next;
  logic [NUM_W-1:0] comp_total, comp_total_next;
  logic             error_seen, error_seen_next;

  logic [LEN_W-1:0] accum_or;
  logic [LEN_W-1:0] left_dec;
  logic [DB_W-1:0]  cont_count;
  logic             comp_found;

  always_comb begin
    accum_or          = length_accum | {{(LEN_W-7){1'b0}}, data_byte[6:0]};
    left_dec          = bytes_left - LEN_W'(1);
    cont_count        = delim_count + DB_W'(1);
    comp_found        = 1'b0;
    in_data_next      = in_data;
    length_accum_next = length_accum;
    delim_count_next  = delim_count;
    bytes_left_next   = bytes_left;
    comp_total_next   = comp_total;
    error_seen_next   = error_seen;

    if (!error_seen) begin
      if (!in_data) begin
        if (delim_count == '0 && data_byte == 8'h80) begin
          // A leading 0x80 byte would make the delimiter non-minimal.
          error_seen_next = 1'b1;
        end else if (data_byte[7]) begin
          delim_count_next  = cont_count;
          length_accum_next = {accum_or[LEN_W-8:0], 7'b0};
          if (cont_count >= DB_W'(MAX_DELIM_BYTES) || final_byte) begin
            error_seen_next = 1'b1;
          end
        end else begin
          length_accum_next = '0;
          delim_count_next  = '0;
          if (final_byte && accum_or != '0) begin
            error_seen_next = 1'b1;
          end else begin
            comp_found = 1'b1;
            if (comp_total != '1) begin
              comp_total_next = comp_total + NUM_W'(1);
            end
            if (accum_or != '0) begin
              in_data_next    = 1'b1;
              bytes_left_next = accum_or;
            end
          end
        end
      end else begin
        bytes_left_next = left_dec;
        if (left_dec == '0) begin
          in_data_next = 1'b0;
        end else if (final_byte) begin
          error_seen_next = 1'b1;
        end
      end
    end

    entry.comp_valid = comp_found;
    entry.comp_len   = accum_or;
    entry.comp_db    = cont_count;
    entry.comp_idx   = comp_total;
    entry.end_valid  = final_byte;
    entry.end_bad    = error_seen_next;
    entry.end_count  = comp_total_next;
    push             = accept && (comp_found || final_byte);

    // The last byte of a name leaves the parser ready for the next name.
    if (final_byte) begin
      in_data_next      = 1'b0;
      length_accum_next = '0;
      delim_count_next  = '0;
      bytes_left_next   = '0;
      comp_total_next   = '0;
      error_seen_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_data      <= 1'b0;
      length_accum <= '0;
      delim_count  <= '0;
      bytes_left   <= '0;
      comp_total   <= '0;
      error_seen   <= 1'b0;
    end else if (accept) begin
      in_data      <= in_data_next;
      length_accum <= length_accum_next;
      delim_count  <= delim_count_next;
      bytes_left   <= bytes_left_next;
      comp_total   <= comp_total_next;
      error_seen   <= error_seen_next;
    end
  end

endmodule
`default_nettype wire

// File: hdl/fncp_queue.sv
// Short first-in first-out queue of result entries between front and back.
`default_nettype none
module fncp_queue
  import fncp_pkg::*;
#(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_entry,
  output logic        full,
  output logic        head_valid,
  output entry_t      head,
  input  wire logic   pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop && head_valid) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push && !full, pop && head_valid})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hdl/fncp_back.sv
// Back part: turns queued entries into output beats through an output register.
`default_nettype none
module fncp_back
  import fncp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        head_valid,
  input  wire entry_t      head,
  output logic             pop,
  input  wire logic        out_ready,
  output logic             out_valid,
  output kind_t            out_kind,
  output logic [LEN_W-1:0] out_len,
  output logic [DB_W-1:0]  out_db,
  output logic [NUM_W-1:0] out_num,
  output logic             out_last
);

  // Set once the component beat of the head entry is out and its end beat remains.
  logic phase, phase_next;
  logic load;
  logic send_comp;

  always_comb begin
    load       = head_valid && (!out_valid || out_ready);
    send_comp  = !phase && head.comp_valid;
    pop        = load && !(send_comp && head.end_valid);
    phase_next = phase;
    if (load) begin
      phase_next = send_comp && head.end_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (send_comp) begin
        out_kind <= KIND_COMP;
        out_len  <= head.comp_len;
        out_db   <= head.comp_db;
        out_num  <= head.comp_idx;
        out_last <= !head.end_valid;
      end else begin
        out_kind <= head.end_bad ? KIND_BAD : KIND_DONE;
        out_len  <= '0;
        out_db   <= '0;
        out_num  <= head.end_bad ? '0 : head.end_count;
        out_last <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/flat_name_component_parser_core.sv
// A byte's result passes through the result queue and then the output register.
// Throughput: one byte per cycle while the queue is not full; a byte that causes two
// results (a component and the end of the name) gives two beats, absorbed by the queue.
// Reset (rst, synchronous, active high) clears the parser state, empties the
// queue, drops m_tvalid and s_tready; the block takes a byte in the cycle after it.
`default_nettype none
module flat_name_component_parser_core
  import fncp_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,  // [7:0] data_byte
  input  wire logic        s_tlast,  // final_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,  // [20:0] data_length, [22:21] delim_bytes,
                                     // [38:23] comp_number, [39] zero
  output logic [1:0]       m_tuser,  // [1:0] kind
  output logic             m_tlast   // run_end
);

  logic             accept;
  logic             push;
  entry_t           push_entry;
  logic             full;
  logic             head_valid;
  entry_t           head;
  logic             pop;
  kind_t            out_kind;
  logic [LEN_W-1:0] out_len;
  logic [DB_W-1:0]  out_db;
  logic [NUM_W-1:0] out_num;

  assign s_tready = !rst && !full;
  assign accept   = s_tvalid && s_tready;

  fncp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (s_tdata),
    .final_byte (s_tlast),
    .push       (push),
    .entry      (push_entry)
  );

  fncp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  fncp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_kind   (out_kind),
    .out_len    (out_len),
    .out_db     (out_db),
    .out_num    (out_num),
    .out_last   (m_tlast)
  );

  assign m_tdata = {1'b0, out_num, out_db, out_len};
  assign m_tuser = out_kind;

endmodule
`default_nettype wire

// File: hdl/fncp_checker.sv
// Port-level checks of the parser core, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module fncp_checker
  import fncp_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata,
  input wire logic [1:0]  m_tuser,
  input wire logic        m_tlast
);

  `ASSERT_CLK(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "output beat changed while stalled")
  `ASSERT_IMPL(a_kind_known, clk, rst, m_tvalid, m_tuser != 2'd3, "unknown result kind")
  `ASSERT_IMPL(a_end_fields, clk, rst, m_tvalid && m_tuser != KIND_COMP, m_tdata[22:0] == 23'd0 && m_tlast, "end beat with length or delimiter size or not last")
  `ASSERT_IMPL(a_comp_delim, clk, rst, m_tvalid && m_tuser == KIND_COMP, m_tdata[22:21] != 2'd0, "component beat without delimiter size")
  `ASSERT_IMPL(a_bad_zero, clk, rst, m_tvalid && m_tuser == KIND_BAD, m_tdata[38:23] == 16'd0, "error beat carries a count")

endmodule

bind flat_name_component_parser_core fncp_checker u_fncp_checker (.*);
`default_nettype wire
